FILE: hdl/cps_pkg.sv
// Package: types and constants for the chunk progress scoreboard.
`timescale 1ns / 1ps
package cps_pkg;
    localparam int MaxChunks = 1024;
    localparam int IdxW = $clog2(MaxChunks);
    localparam int CntW = 11;

    typedef enum logic [2:0] {
        OP_INIT = 3'd0, OP_SET = 3'd1, OP_VERIFY = 3'd2, OP_RETRY = 3'd3,
        OP_CLAIM = 3'd4, OP_READ = 3'd5, OP_RESET_INC = 3'd6, OP_COMPLETE = 3'd7
    } op_t;

    localparam logic [2:0] ST_PENDING  = 3'd0;
    localparam logic [2:0] ST_READING  = 3'd1;
    localparam logic [2:0] ST_VERIFIED = 3'd2;
    localparam logic [2:0] ST_FAILED   = 3'd3;
    localparam logic [2:0] ST_SPARSE   = 3'd4;
    localparam logic [2:0] ST_DELTA    = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_RD, S_RD2, S_SCAN, S_COUNT, S_OUT, S_BOOT
    } fsm_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [9:0]  chunk_index;
        logic [2:0]  new_state;
        logic [63:0] hash_low;
        logic [63:0] hash_high;
        logic [63:0] time_now;
    } cmd_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  claimed_index;
        logic [2:0]  chunk_state;
        logic [15:0] retries_out;
        logic [63:0] hash_low_out;
        logic [63:0] hash_high_out;
        logic [63:0] stamp;
        logic [10:0] verified_total;
        logic [10:0] failed_total;
        logic [10:0] pending_total;
        logic [10:0] skipped_total;
        logic        transfer_done;
    } res_t;
endpackage

FILE: hdl/cps_if.sv
// Interfaces: valid/ready channels for commands, results and configuration.
`timescale 1ns / 1ps
interface cps_cmd_if import cps_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cps_res_if import cps_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cps_cfg_if ();
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/chunk_progress_scoreboard.sv
// Top level: chunk progress scoreboard with memory records and a scan sequencer.
// The chunk count in use is held at 1024 at most. Init first clears the records; claim and the
// reset of unfinished chunks first scan the records; each op ends in a recount.
// One item at a time; a new command is taken only after the result word has left.
// Reset clears control state, counters, the completed flag and the chunk count, then a
// clearing pass runs over all 1024 records before the first command is taken.
`timescale 1ns / 1ps
module chunk_progress_scoreboard import cps_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    cps_cmd_if.sink   cmd,
    cps_res_if.source res,
    cps_cfg_if.sink   cfg
);
    typedef struct packed {
        logic [2:0]  st;
        logic [15:0] rc;
        logic [63:0] hl;
        logic [63:0] hh;
        logic [63:0] ts;
    } rec_t;

    rec_t mem [MaxChunks];
    rec_t rd_reg;

    fsm_t state_reg, state_next;
    cmd_t cmd_reg;
    res_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;
    logic [10:0] count_reg;
    logic [IdxW:0] ptr_reg, ptr_next;
    logic [IdxW-1:0] rd_addr;
    logic we;
    logic [IdxW-1:0] wa;
    rec_t wd;
    logic [CntW-1:0] v_reg, f_reg, p_reg, s_reg, v_next, f_next, p_next, s_next;
    logic done_reg, done_next;
    logic hit_reg, hit_next;
    logic [IdxW-1:0] sel_reg, sel_next;
    logic [10:0] n_eff;
    logic valid_idx;

    assign n_eff = (count_reg > 11'(MaxChunks)) ? 11'(MaxChunks) : count_reg;
    assign valid_idx = {1'b0, cmd_reg.chunk_index} < n_eff;

    assign cmd.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign cfg.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            res_valid_reg <= 1'b0;
            count_reg <= '0;
            ptr_reg <= '0;
            v_reg <= '0;
            f_reg <= '0;
            p_reg <= '0;
            s_reg <= '0;
            done_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
            ptr_reg <= ptr_next;
            v_reg <= v_next;
            f_reg <= f_next;
            p_reg <= p_next;
            s_reg <= s_next;
            done_reg <= done_next;
            hit_reg <= hit_next;
            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        res_reg <= res_next;
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= cmd.data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_valid_next = res_valid_reg;
        res_next = res_reg;
        ptr_next = ptr_reg;
        v_next = v_reg;
        f_next = f_reg;
        p_next = p_reg;
        s_next = s_reg;
        done_next = done_reg;
        hit_next = hit_reg;
        sel_next = sel_reg;
        rd_addr = ptr_reg[IdxW-1:0];
        we = 1'b0;
        wa = ptr_reg[IdxW-1:0];
        wd = rd_reg;
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                ptr_next = '0;
                hit_next = 1'b0;
                if (cmd.valid && cmd.ready)
                begin
                    unique case (op_t'(cmd.data.operation))
                        OP_INIT: state_next = S_CLEAR;
                        OP_CLAIM, OP_RESET_INC: state_next = S_SCAN;
                        OP_COMPLETE: state_next = S_COUNT;
                        default: state_next = S_RD;
                    endcase
                end
            end
            S_BOOT:
            begin
                we = 1'b1;
                wd = '0;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == (IdxW+1)'(MaxChunks - 1))
                begin
                    ptr_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                we = 1'b1;
                wd = '0;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == (IdxW+1)'(MaxChunks - 1))
                begin
                    ptr_next = '0;
                    done_next = 1'b0;
                    state_next = S_COUNT;
                end
            end
            S_RD:
            begin
                rd_addr = cmd_reg.chunk_index;
                sel_next = cmd_reg.chunk_index;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                wa = cmd_reg.chunk_index;
                wd = rd_reg;
                hit_next = valid_idx;
                unique case (op_t'(cmd_reg.operation))
                    OP_SET:
                    begin
                        hit_next = valid_idx && (cmd_reg.new_state <= ST_DELTA);
                        wd.st = cmd_reg.new_state;
                        wd.ts = cmd_reg.time_now;
                    end
                    OP_VERIFY:
                    begin
                        wd.st = ST_VERIFIED;
                        wd.hl = cmd_reg.hash_low;
                        wd.hh = cmd_reg.hash_high;
                        wd.ts = cmd_reg.time_now;
                    end
                    OP_RETRY:
                    begin
                        if (rd_reg.rc != 16'hFFFF)
                        begin
                            wd.rc = rd_reg.rc + 16'd1;
                        end
                    end
                    default: wd = rd_reg;
                endcase
                we = hit_next;
                ptr_next = '0;
                state_next = S_COUNT;
            end
            S_SCAN:
            begin
                if (ptr_reg[0] == 1'b0)
                begin
                    rd_addr = ptr_reg[IdxW:1];
                    if ((IdxW+1)'(ptr_reg[IdxW:1]) >= (IdxW+1)'(n_eff))
                    begin
                        ptr_next = '0;
                        state_next = S_COUNT;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                else
                begin
                    wa = ptr_reg[IdxW:1];
                    wd = rd_reg;
                    ptr_next = ptr_reg + 1'b1;
                    if (({1'b0, ptr_reg[IdxW:1]} + 11'd1) >= n_eff)
                    begin
                        ptr_next = '0;
                        state_next = S_COUNT;
                    end
                    if (cmd_reg.operation == OP_CLAIM)
                    begin
                        if (rd_reg.st == ST_PENDING)
                        begin
                            wd.st = ST_READING;
                            we = 1'b1;
                            hit_next = 1'b1;
                            sel_next = ptr_reg[IdxW:1];
                            ptr_next = '0;
                            state_next = S_COUNT;
                        end
                    end
                    else if (rd_reg.st != ST_VERIFIED && rd_reg.st != ST_SPARSE
                             && rd_reg.st != ST_DELTA)
                    begin
                        wd.st = ST_PENDING;
                        wd.rc = '0;
                        we = 1'b1;
                    end
                end
                if (state_next == S_COUNT && cmd_reg.operation == OP_RESET_INC)
                begin
                    done_next = 1'b0;
                end
            end
            S_COUNT:
            begin
                if (ptr_reg == 0)
                begin
                    v_next = '0;
                    f_next = '0;
                    p_next = '0;
                    s_next = '0;
                    if (cmd_reg.operation == OP_COMPLETE)
                    begin
                        done_next = 1'b1;
                    end
                end
                rd_addr = ptr_reg[IdxW-1:0];
                if (ptr_reg != 0 && (ptr_reg - 1'b1) < (IdxW+1)'(n_eff))
                begin
                    unique case (rd_reg.st)
                        ST_VERIFIED: v_next = (v_reg == '1) ? v_reg : v_reg + 1'b1;
                        ST_FAILED: f_next = (f_reg == '1) ? f_reg : f_reg + 1'b1;
                        ST_PENDING: p_next = (p_reg == '1) ? p_reg : p_reg + 1'b1;
                        ST_SPARSE, ST_DELTA: s_next = (s_reg == '1) ? s_reg : s_reg + 1'b1;
                        default: v_next = v_reg;
                    endcase
                end
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg >= (IdxW+1)'(n_eff))
                begin
                    rd_addr = sel_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                res_next = '0;
                if (hit_reg)
                begin
                    res_next.found = 1'b1;
                    res_next.claimed_index = 10'(sel_reg);
                    res_next.chunk_state = rd_reg.st;
                    res_next.retries_out = rd_reg.rc;
                    res_next.hash_low_out = rd_reg.hl;
                    res_next.hash_high_out = rd_reg.hh;
                    res_next.stamp = rd_reg.ts;
                end
                res_next.verified_total = v_reg;
                res_next.failed_total = f_reg;
                res_next.pending_total = p_reg;
                res_next.skipped_total = s_reg;
                res_next.transfer_done = done_reg;
                res_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
